// ===== design/bht_pkg.sv =====
// ----------------------------------------------------------------------------
// bht_pkg
// Shared types, constants and helper functions of the button hold tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bht_pkg;

  // Field widths fixed by the frame format
  localparam int unsigned JOY_W     = 12;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned BTN_IDX_W = 3;
  localparam int unsigned CFG_AW    = 2;
  localparam int unsigned CFG_DW    = 8;

  // Joystick thresholds
  localparam logic [JOY_W-1:0] JOY_HIGH = 12'd3072;
  localparam logic [JOY_W-1:0] JOY_LOW  = 12'd1024;

  // Counter codes
  localparam logic [CNT_W-1:0] CNT_IDLE     = 8'h00;
  localparam logic [CNT_W-1:0] CNT_FIRST    = 8'h01;
  localparam logic [CNT_W-1:0] CNT_MAX      = 8'hFE;
  localparam logic [CNT_W-1:0] CNT_RELEASED = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_HOLD_FRAMES   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_REPEAT_PERIOD = 2'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_MOD,
    S_LOAD
  } seq_state_t;

  // Decode joystick samples and active-low buttons into eight levels
  function automatic logic [MASK_W-1:0] decode_levels(
    input logic [JOY_W-1:0] joy_x,
    input logic [JOY_W-1:0] joy_y,
    input logic             btn_a_n,
    input logic             btn_b_n,
    input logic             btn_sel_n,
    input logic             btn_sys_n
  );
    logic [MASK_W-1:0] lv;
    lv    = '0;
    lv[3] = (joy_y > JOY_HIGH);
    lv[0] = (joy_y <= JOY_HIGH) && (joy_y > JOY_LOW);
    lv[1] = (joy_x > JOY_HIGH);
    lv[2] = (joy_x <= JOY_HIGH) && (joy_x > JOY_LOW);
    lv[4] = ~btn_a_n;
    lv[5] = ~btn_b_n;
    lv[6] = ~btn_sel_n;
    lv[7] = ~btn_sys_n;
    return lv;
  endfunction

  // Advance one button counter by one frame
  function automatic logic [CNT_W-1:0] next_count(
    input logic [CNT_W-1:0] c,
    input logic             down
  );
    logic [CNT_W-1:0] n;
    if (down) begin
      if (c < CNT_MAX) begin
        n = c + CNT_FIRST;
      end else if (c == CNT_RELEASED) begin
        n = CNT_FIRST;
      end else begin
        n = c;
      end
    end else if (c == CNT_IDLE || c == CNT_RELEASED) begin
      n = CNT_IDLE;
    end else begin
      n = CNT_RELEASED;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== design/bht_item_if.sv =====
// ----------------------------------------------------------------------------
// bht_item_if
// Frame tick channel: joystick samples, button levels and query index.
// ----------------------------------------------------------------------------
`default_nettype none

interface bht_item_if;
  import bht_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [JOY_W-1:0]     joy_x;
  logic [JOY_W-1:0]     joy_y;
  logic                 btn_a_n;
  logic                 btn_b_n;
  logic                 btn_sel_n;
  logic                 btn_sys_n;
  logic [BTN_IDX_W-1:0] query_button;

  modport source (
    output valid, joy_x, joy_y, btn_a_n, btn_b_n, btn_sel_n, btn_sys_n, query_button,
    input  ready
  );

  modport sink (
    input  valid, joy_x, joy_y, btn_a_n, btn_b_n, btn_sel_n, btn_sys_n, query_button,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/bht_result_if.sv =====
// ----------------------------------------------------------------------------
// bht_result_if
// Result channel: per-button event masks and hold time of the queried button.
// ----------------------------------------------------------------------------
`default_nettype none

interface bht_result_if;
  import bht_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] pressed_mask;
  logic [MASK_W-1:0] released_mask;
  logic [MASK_W-1:0] held_mask;
  logic [MASK_W-1:0] repeat_mask;
  logic [CNT_W-1:0]  time_held;

  modport source (
    output valid, pressed_mask, released_mask, held_mask, repeat_mask, time_held,
    input  ready
  );

  modport sink (
    input  valid, pressed_mask, released_mask, held_mask, repeat_mask, time_held,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/bht_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bht_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface bht_cfg_if;
  import bht_pkg::*;

  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;

  modport source (
    output valid, addr, data,
    input  ready
  );

  modport sink (
    input  valid, addr, data,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/bht_cnt_mem.sv =====
// ----------------------------------------------------------------------------
// bht_cnt_mem
// Button counter store: one write port, one read port with registered data.
// Per-entry valid bits make unwritten entries read as idle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bht_cnt_mem #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = 3
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     rd_en,
  input  wire logic [ADDR_W-1:0]        rd_addr,
  output logic      [bht_pkg::CNT_W-1:0] rd_data,
  input  wire logic                     wr_en,
  input  wire logic [ADDR_W-1:0]        wr_addr,
  input  wire logic [bht_pkg::CNT_W-1:0] wr_data
);
  import bht_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark written entries
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Registered read; an unwritten entry reads idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : CNT_IDLE;
    end
  end

endmodule

`default_nettype wire

// ===== design/bht_mod_unit.sv =====
// ----------------------------------------------------------------------------
// bht_mod_unit
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bht_mod_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [bht_pkg::CNT_W-1:0] dividend,
  input  wire logic [bht_pkg::CNT_W-1:0] divisor,
  output logic                           done,
  output logic      [bht_pkg::CNT_W-1:0] rem
);
  import bht_pkg::*;

  localparam int unsigned STEP_W = $clog2(CNT_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  dvd;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, dvd[CNT_W-1]};
    diff  = trial - {1'b0, dsr};
  end

  // Control: step count, busy and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !start && (step == STEP_W'(CNT_W - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(CNT_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[CNT_W-2:0], 1'b0};
      if (!diff[CNT_W]) begin
        rem <= diff[CNT_W-1:0];
      end else begin
        rem <= trial[CNT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/button_hold_tracker.sv =====
// ----------------------------------------------------------------------------
// button_hold_tracker
// Each accepted frame tick decodes two joystick samples and four active-low
// buttons into eight button levels, advances one 8-bit counter per button and
// returns pressed, released, held and repeat masks plus the hold time of the
// queried button. The counters live in a small synchronous memory that a
// sequencer walks one button at a time: it reads the counter, computes and
// writes it back, then waits on the shared bit-serial remainder unit for the
// repeat rule (eight bit steps, then the completion pulse). One frame is
// processed at a time. The finished result sits in an output register, so
// the next frame tick is taken while it waits. Configuration writes are
// taken every cycle and must only be issued while no frame is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module button_hold_tracker #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input wire logic clk,
  input wire logic rst,
  bht_cfg_if.sink      cfg,
  bht_item_if.sink     item,
  bht_result_if.source result
);
  import bht_pkg::*;

  localparam int unsigned ADDR_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [BTN_IDX_W-1:0] LAST_BTN = BTN_IDX_W'(NUM_BUTTONS - 1);

  // Configuration registers
  logic [CNT_W-1:0] hold_frames;
  logic [CNT_W-1:0] repeat_period;

  // Sequencer
  seq_state_t state;
  seq_state_t state_next;
  logic [BTN_IDX_W-1:0] btn;
  logic [MASK_W-1:0]    levels;
  logic [BTN_IDX_W-1:0] query;
  logic [CNT_W-1:0]     cnt;

  // Accumulated results
  logic [MASK_W-1:0] pm;
  logic [MASK_W-1:0] rm;
  logic [MASK_W-1:0] hm;
  logic [MASK_W-1:0] tm;
  logic [CNT_W-1:0]  qt;

  // Output register
  logic              res_valid;
  logic [MASK_W-1:0] res_pm;
  logic [MASK_W-1:0] res_rm;
  logic [MASK_W-1:0] res_hm;
  logic [MASK_W-1:0] res_tm;
  logic [CNT_W-1:0]  res_qt;

  // Memory and remainder unit hookup
  logic             rd_en;
  logic             wr_en;
  logic [CNT_W-1:0] rd_data;
  logic [CNT_W-1:0] c_next;
  logic             mod_start;
  logic             mod_done;
  logic [CNT_W-1:0] mod_rem;
  logic             load;
  logic             accept;
  logic             rep_hit;

  bht_cnt_mem #(
    .DEPTH  (NUM_BUTTONS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (btn[ADDR_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (btn[ADDR_W-1:0]),
    .wr_data (c_next)
  );

  bht_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (c_next),
    .divisor  (repeat_period),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Configuration writes; out-of-range indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_frames   <= CNT_FIRST;
      repeat_period <= CNT_FIRST;
    end else if (cfg.valid) begin
      if (cfg.addr == REG_HOLD_FRAMES) begin
        hold_frames <= cfg.data;
      end else if (cfg.addr == REG_REPEAT_PERIOD) begin
        repeat_period <= cfg.data;
      end
    end
  end

  // Counter update for the button being walked
  assign c_next = next_count(rd_data, levels[btn]);

  // Repeat rule on the held count
  assign rep_hit = (cnt != CNT_IDLE) && (cnt != CNT_RELEASED) &&
                   ((repeat_period <= CNT_FIRST) || (mod_rem == CNT_FIRST));

  assign accept = item.valid && item.ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control strobes
  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    mod_start  = 1'b0;
    load       = 1'b0;
    case (state)
      S_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        wr_en      = 1'b1;
        mod_start  = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        if (mod_done) begin
          state_next = (btn == LAST_BTN) ? S_LOAD : S_READ;
        end
      end
      S_LOAD: begin
        if (!res_valid || result.ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      btn <= '0;
    end else if (accept) begin
      btn <= '0;
    end else if (state == S_MOD && mod_done && btn != LAST_BTN) begin
      btn <= btn + 1'b1;
    end
  end

  // Frame capture and mask accumulation
  always_ff @(posedge clk) begin
    if (accept) begin
      levels <= decode_levels(item.joy_x, item.joy_y, item.btn_a_n, item.btn_b_n,
                              item.btn_sel_n, item.btn_sys_n);
      query  <= item.query_button;
      pm     <= '0;
      rm     <= '0;
      hm     <= '0;
      tm     <= '0;
      qt     <= CNT_IDLE;
    end else if (state == S_CALC) begin
      cnt     <= c_next;
      pm[btn] <= (c_next == CNT_FIRST);
      rm[btn] <= (c_next == CNT_RELEASED);
      hm[btn] <= ({1'b0, c_next} == ({1'b0, hold_frames} + 9'd1));
      if (btn == query) begin
        qt <= (c_next == CNT_RELEASED) ? CNT_IDLE : c_next;
      end
    end else if (state == S_MOD && mod_done) begin
      tm[btn] <= rep_hit;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_pm <= pm;
      res_rm <= rm;
      res_hm <= hm;
      res_tm <= tm;
      res_qt <= qt;
    end
  end

  assign result.valid         = res_valid;
  assign result.pressed_mask  = res_pm;
  assign result.released_mask = res_rm;
  assign result.held_mask     = res_hm;
  assign result.repeat_mask   = res_tm;
  assign result.time_held     = res_qt;

`ifndef SYNTHESIS
  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_MOD)
    else $error("remainder completed outside the wait state");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ && btn == '0))
    else $error("accepted frame did not start at the first button");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_CALC || state == S_MOD) |-> btn <= LAST_BTN)
    else $error("walk index beyond the last button");

  a_load_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && res_valid && !result.ready) |=> state == S_LOAD)
    else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire
